/* rtl/mamd_pkg.sv */
// Shared types, operation codes and sizes for the MIPS ALU with multiply and divide.
`default_nettype none

package mamd_pkg;

    // Data word width and the number of one-bit divide steps.
    localparam int WORD_W    = 32;
    localparam int DIV_STEPS = WORD_W;

    // Operation codes; codes 13 to 15 mean nothing and give an all-zero result.
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_AND = 4'd1,
        OP_DIV = 4'd2,
        OP_EQ  = 4'd3,
        OP_LT  = 4'd4,
        OP_MUL = 4'd5,
        OP_NEQ = 4'd6,
        OP_OR  = 4'd7,
        OP_SLL = 4'd8,
        OP_SRA = 4'd9,
        OP_SRL = 4'd10,
        OP_SUB = 4'd11,
        OP_XOR = 4'd12
    } op_t;

    // One input item.
    typedef struct packed {
        logic signed [WORD_W-1:0] left_operand;
        logic signed [WORD_W-1:0] right_operand;
        logic        [3:0]        operation;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [WORD_W-1:0] low_result;
        logic signed [WORD_W-1:0] high_result;
        logic                     high_written;
    } out_item_t;

    // Contents of one pipeline stage between the front end and the output.
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              div_zero;
        logic              q_neg;
        logic              r_neg;
        logic              hw;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] dvd;
        logic [WORD_W-1:0] dvs;
    } stage_t;

endpackage

`default_nettype wire

/* rtl/mamd_div_step.sv */
// One registered restoring-division step that settles one quotient bit.
`default_nettype none

module mamd_div_step (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire mamd_pkg::stage_t prev,
    output mamd_pkg::stage_t      curr
);

    logic [mamd_pkg::WORD_W:0]   rem_shift;
    logic [mamd_pkg::WORD_W:0]   diff;
    logic                        q_bit;
    mamd_pkg::stage_t            curr_next;
    mamd_pkg::stage_t            stage_reg;

    assign curr = stage_reg;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    always_comb
    begin
        rem_shift = {prev.rem, prev.dvd[mamd_pkg::WORD_W-1]};
        diff      = rem_shift - {1'b0, prev.dvs};
        q_bit     = ~diff[mamd_pkg::WORD_W];
        curr_next = prev;
        curr_next.rem = q_bit ? diff[mamd_pkg::WORD_W-1:0]
                              : rem_shift[mamd_pkg::WORD_W-1:0];
        // Quotient bits fill the dividend register from the bottom.
        curr_next.dvd = {prev.dvd[mamd_pkg::WORD_W-2:0], q_bit};
    end

    // Stage register; reset clears it and a stall holds it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= curr_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mips_alu_mul_div.sv */
// Top level of the pipelined MIPS ALU with signed multiply and divide.
//
//   Channel   Valid           Stall           Payload
//   operands  operand_valid   operand_stall   operands (left, right, operation)
//   result    result_valid    result_stall    result (low, high, high_written)
//
// Every item passes from acceptance to its result through one front-end stage
// (simple ops, 32x32 multiplier, divide setup), 32 one-bit divide stages, one
// output stage. The divide stages set the depth. A new item is taken every cycle
// unless held. Reset clears all pipeline registers but the output payload. The
// whole pipeline holds while a valid result is stalled; operand_stall follows it.
`default_nettype none

module mips_alu_mul_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                operand_valid,
    output logic                     operand_stall,
    input  wire mamd_pkg::in_item_t  operands,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output mamd_pkg::out_item_t      result
);

    localparam int W = mamd_pkg::WORD_W;

    logic                    en;
    mamd_pkg::stage_t        front_next;
    mamd_pkg::stage_t        front_reg;
    mamd_pkg::stage_t        pipe [0:mamd_pkg::DIV_STEPS];
    logic signed [2*W-1:0]   product;
    logic [4:0]              shamt;
    logic [W-1:0]            a_u;
    logic [W-1:0]            b_u;
    mamd_pkg::out_item_t     result_next;
    logic                    result_valid_reg;
    mamd_pkg::out_item_t     result_reg;
    logic [W-1:0]            quo;
    logic [W-1:0]            rmd;

    // The pipeline moves unless a finished result waits.
    assign en            = !(result_valid_reg && result_stall);
    assign operand_stall = !en;
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;
    assign pipe[0]       = front_reg;

    // Front end: simple operations, the multiplier and divide setup.
    always_comb
    begin
        a_u     = operands.left_operand;
        b_u     = operands.right_operand;
        shamt   = b_u[4:0];
        product = operands.left_operand * operands.right_operand;

        front_next          = '0;
        front_next.valid    = operand_valid;
        front_next.q_neg    = a_u[W-1] ^ b_u[W-1];
        front_next.r_neg    = a_u[W-1];
        front_next.div_zero = (b_u == '0);
        front_next.dvd      = a_u[W-1] ? (~a_u + 1'b1) : a_u;
        front_next.dvs      = b_u[W-1] ? (~b_u + 1'b1) : b_u;

        unique case (operands.operation)
            mamd_pkg::OP_ADD: front_next.lo = a_u + b_u;
            mamd_pkg::OP_AND: front_next.lo = a_u & b_u;
            mamd_pkg::OP_DIV:
            begin
                front_next.is_div = 1'b1;
                front_next.hw     = 1'b1;
                front_next.hi     = a_u;
            end
            mamd_pkg::OP_EQ:  front_next.lo = {{(W-1){1'b0}}, (a_u == b_u)};
            mamd_pkg::OP_LT:
                front_next.lo = {{(W-1){1'b0}},
                                 (operands.left_operand < operands.right_operand)};
            mamd_pkg::OP_MUL:
            begin
                front_next.lo = product[W-1:0];
                front_next.hi = product[2*W-1:W];
                front_next.hw = 1'b1;
            end
            mamd_pkg::OP_NEQ: front_next.lo = {{(W-1){1'b0}}, (a_u != b_u)};
            mamd_pkg::OP_OR:  front_next.lo = a_u | b_u;
            mamd_pkg::OP_SLL: front_next.lo = a_u << shamt;
            mamd_pkg::OP_SRA: front_next.lo = operands.left_operand >>> shamt;
            mamd_pkg::OP_SRL: front_next.lo = a_u >> shamt;
            mamd_pkg::OP_SUB: front_next.lo = a_u - b_u;
            mamd_pkg::OP_XOR: front_next.lo = a_u ^ b_u;
            default:          front_next.lo = '0;
        endcase
    end

    // Front-end stage register; the partial remainder starts at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
        end
    end

    // Divide stages, one quotient bit each; other items ride along.
    for (genvar i = 0; i < mamd_pkg::DIV_STEPS; i++)
    begin : g_div
        mamd_div_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (pipe[i]),
            .curr  (pipe[i+1])
        );
    end

    // Sign correction and selection of the final result.
    always_comb
    begin
        quo = pipe[mamd_pkg::DIV_STEPS].dvd;
        rmd = pipe[mamd_pkg::DIV_STEPS].rem;
        result_next.high_written = pipe[mamd_pkg::DIV_STEPS].hw;
        if (!pipe[mamd_pkg::DIV_STEPS].is_div)
        begin
            result_next.low_result  = pipe[mamd_pkg::DIV_STEPS].lo;
            result_next.high_result = pipe[mamd_pkg::DIV_STEPS].hi;
        end
        else if (pipe[mamd_pkg::DIV_STEPS].div_zero)
        begin
            // Division by zero: all-ones quotient, dividend as remainder.
            result_next.low_result  = '1;
            result_next.high_result = pipe[mamd_pkg::DIV_STEPS].hi;
        end
        else
        begin
            result_next.low_result  = pipe[mamd_pkg::DIV_STEPS].q_neg ? (~quo + 1'b1) : quo;
            result_next.high_result = pipe[mamd_pkg::DIV_STEPS].r_neg ? (~rmd + 1'b1) : rmd;
        end
    end

    // Output register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= pipe[mamd_pkg::DIV_STEPS].valid;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mamd_checker.sv */
// Port-level checker for the MIPS ALU with multiply and divide, and its bind.
`default_nettype none

module mamd_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                operand_valid,
    input wire logic                operand_stall,
    input wire mamd_pkg::in_item_t  operands,
    input wire logic                result_valid,
    input wire logic                result_stall,
    input wire mamd_pkg::out_item_t result
);

    // A stalled result item stays and holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result item changed or vanished");

    // The input side stalls exactly when a finished item waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        operand_stall == (result_valid && result_stall))
        else $error("operand stall does not follow output back-pressure");

    // Only multiply and divide items carry a high word.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.high_written |-> result.high_result == '0)
        else $error("high word set on an item that does not write it");

    // The input side never stalls while the output holds no item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !operand_stall)
        else $error("input stalled while the output was empty");

endmodule

bind mips_alu_mul_div mamd_checker u_mamd_checker (.*);

`default_nettype wire

/* bench/mips_alu_mul_div_tb.sv */
// Self-checking testbench for the pipelined MIPS ALU with signed multiply and divide.
`timescale 1ns / 1ps

module mips_alu_mul_div_tb;

    // Codes with no operation behind them; the ALU answers them with zeros.
    localparam logic [3:0] OP_RSVD_D = 4'd13;
    localparam logic [3:0] OP_RSVD_E = 4'd14;
    localparam logic [3:0] OP_RSVD_F = 4'd15;

    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam int          MAX_IDLE  = 10;
    localparam int          LONG_HOLD = 200;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          QUIET_LIMIT  = 5000;

    // Scoreboard: keeps the ALU results still owed and checks the ones that arrive.
    class alu_scoreboard;
        mamd_pkg::out_item_t expected_results[$];
        int unsigned         mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Computes the result the ALU must give for one set of operands.
        function mamd_pkg::out_item_t alu_predict(mamd_pkg::in_item_t it);
            mamd_pkg::out_item_t r;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] lo;
            logic [31:0] hi;
            logic [63:0] prod;
            logic [4:0]  sh;
            a  = it.left_operand;
            b  = it.right_operand;
            sh = b[4:0];
            lo = '0;
            hi = '0;
            r  = '0;
            case (it.operation)
                mamd_pkg::OP_ADD: lo = a + b;
                mamd_pkg::OP_AND: lo = a & b;
                mamd_pkg::OP_DIV:
                begin
                    r.high_written = 1'b1;
                    if (b == '0)
                    begin
                        lo = ALL_ONES;
                        hi = a;
                    end
                    else if (a == WORD_MIN && b == ALL_ONES)
                    begin
                        lo = WORD_MIN;
                        hi = '0;
                    end
                    else
                    begin
                        lo = $signed(a) / $signed(b);
                        hi = $signed(a) % $signed(b);
                    end
                end
                mamd_pkg::OP_EQ:  lo = {31'd0, a == b};
                mamd_pkg::OP_LT:  lo = {31'd0, $signed(a) < $signed(b)};
                mamd_pkg::OP_MUL:
                begin
                    prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                    lo   = prod[31:0];
                    hi   = prod[63:32];
                    r.high_written = 1'b1;
                end
                mamd_pkg::OP_NEQ: lo = {31'd0, a != b};
                mamd_pkg::OP_OR:  lo = a | b;
                mamd_pkg::OP_SLL: lo = a << sh;
                mamd_pkg::OP_SRA: lo = $signed(a) >>> sh;
                mamd_pkg::OP_SRL: lo = a >> sh;
                mamd_pkg::OP_SUB: lo = a - b;
                mamd_pkg::OP_XOR: lo = a ^ b;
                default: r.high_written = 1'b0;
            endcase
            r.low_result  = lo;
            r.high_result = hi;
            return r;
        endfunction

        function void note_operands(mamd_pkg::in_item_t it);
            expected_results.push_back(alu_predict(it));
        endfunction

        function void check_result(mamd_pkg::out_item_t got);
            mamd_pkg::out_item_t want;
            if (expected_results.size() == 0)
            begin
                $error("result item with nothing pending: low %h high %h hw %0d",
                       got.low_result, got.high_result, got.high_written);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.low_result !== want.low_result)
            begin
                $error("low_result: expected %h, got %h", want.low_result, got.low_result);
                mismatches++;
            end
            if (got.high_result !== want.high_result)
            begin
                $error("high_result: expected %h, got %h", want.high_result, got.high_result);
                mismatches++;
            end
            if (got.high_written !== want.high_written)
            begin
                $error("high_written: expected %0d, got %0d",
                       want.high_written, got.high_written);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                operand_valid = 1'b0;
    logic                operand_stall;
    mamd_pkg::in_item_t  operands = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    mamd_pkg::out_item_t result;

    alu_scoreboard sb = new();

    // Idling switches and the long receiver hold-off, set by the stimulus process.
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    mips_alu_mul_div u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operands      (operands),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watchdog: ends the run when neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((operand_valid && !operand_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic mamd_pkg::in_item_t make_item(logic [31:0] a, logic [31:0] b,
                                                     logic [3:0] op);
        mamd_pkg::in_item_t it;
        it.left_operand  = a;
        it.right_operand = b;
        it.operation     = op;
        return it;
    endfunction

    // Operand values lean toward the corners: zero, one, minus one, MIN, MAX, small values.
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            4:
            begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = 32'd1;
                    2: v = ALL_ONES;
                    3: v = WORD_MIN;
                    default: v = WORD_MAX;
                endcase
            end
            5: v = $urandom_range(0, 64) - 32;
            6: v = $urandom >> $urandom_range(0, 31);
            7: v = -($urandom >> $urandom_range(0, 31));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic mamd_pkg::in_item_t random_item();
        return make_item(pick_operand(), pick_operand(),
                         4'($urandom_range(mamd_pkg::OP_ADD, OP_RSVD_F)));
    endfunction

    // Offers one item after a random gap and returns once it has been accepted.
    task automatic send_operands(mamd_pkg::in_item_t it);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            operand_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_valid <= 1'b1;
        operands      <= it;
        do
            @(posedge clk);
        while (operand_stall);
        sb.note_operands(it);
    endtask

    task automatic send_random(int count);
        repeat (count) send_operands(random_item());
    endtask

    // Stops offering items and waits until every owed result has come back.
    task automatic wait_results_drained();
        operand_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
    endtask

    // Result side: stalls at random, takes one item at a time and checks it.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            sb.check_result(result);
        end
    end

    // Stimulus: reset, directed corners, then random phases with different idling.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Wrapping, logic ops and comparisons at the extremes.
        send_operands(make_item(WORD_MAX, 32'd1, mamd_pkg::OP_ADD));
        send_operands(make_item(WORD_MIN, 32'd1, mamd_pkg::OP_SUB));
        send_operands(make_item(ALL_ONES, 32'hA5A5_5A5A, mamd_pkg::OP_AND));
        send_operands(make_item(32'h0F0F_0F0F, WORD_MIN, mamd_pkg::OP_OR));
        send_operands(make_item(ALL_ONES, 32'h1234_5678, mamd_pkg::OP_XOR));
        send_operands(make_item(WORD_MIN, WORD_MIN, mamd_pkg::OP_EQ));
        send_operands(make_item(WORD_MAX, WORD_MAX, mamd_pkg::OP_NEQ));
        send_operands(make_item(WORD_MIN, WORD_MAX, mamd_pkg::OP_LT));
        send_operands(make_item(WORD_MAX, WORD_MIN, mamd_pkg::OP_LT));
        // Full 64-bit products with sign.
        send_operands(make_item(WORD_MIN, WORD_MIN, mamd_pkg::OP_MUL));
        send_operands(make_item(ALL_ONES, WORD_MAX, mamd_pkg::OP_MUL));
        // Division: signs of quotient and remainder, divide by zero, MIN over minus one.
        send_operands(make_item(32'd7, -32'sd2, mamd_pkg::OP_DIV));
        send_operands(make_item(-32'sd7, 32'd2, mamd_pkg::OP_DIV));
        send_operands(make_item(WORD_MIN, '0, mamd_pkg::OP_DIV));
        send_operands(make_item(WORD_MIN, ALL_ONES, mamd_pkg::OP_DIV));
        send_operands(make_item(WORD_MAX, WORD_MIN, mamd_pkg::OP_DIV));
        // Shifts use only the low five bits of the amount.
        send_operands(make_item(ALL_ONES, ALL_ONES, mamd_pkg::OP_SLL));
        send_operands(make_item(WORD_MIN, 32'd63, mamd_pkg::OP_SRA));
        send_operands(make_item(ALL_ONES, 32'd32, mamd_pkg::OP_SRA));
        send_operands(make_item(WORD_MIN, 32'd4, mamd_pkg::OP_SRL));
        // Unused codes.
        send_operands(make_item(ALL_ONES, ALL_ONES, OP_RSVD_D));
        send_operands(make_item(WORD_MIN, 32'd1, OP_RSVD_E));
        send_operands(make_item(WORD_MAX, ALL_ONES, OP_RSVD_F));

        // Back to back on both sides.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_random(400);

        // Hold the result side off long enough for the pipeline to fill and stall input.
        hold_cycles = LONG_HOLD;
        send_random(100);
        wait_results_drained();

        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_random(600);

        recv_idle = 1'b0;
        send_random(300);
        wait_results_drained();

        send_idle = 1'b0;
        recv_idle = 1'b1;
        send_random(350);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
